@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and sizes shared by the sorted priority queue files.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Number of entries the queue holds.
   localparam int DEPTH = 16;
   // Width of a count that can hold DEPTH itself.
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 8;

   // Input item commands.
   typedef enum logic [0:0] {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } command_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // One stored entry.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } entry_type;

   // Control broadcast to every cell of the row.
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, compares it with the broadcast
// priority and takes its own, the new or a neighbor's entry each cycle.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   left_le,
   input  spq_pkg::entry_type     left_entry,
   input  spq_pkg::entry_type     right_entry,
   output logic                   le,
   output spq_pkg::entry_type     entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // This slot stays ahead of a new entry when it is occupied and holds an equal or lower priority.
   assign le = occupied && (entry_ff.prio <= ctrl.new_entry.prio);

   // Insert shifts toward the tail behind the insertion point; remove shifts
   // toward the head.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (!le) begin
            if (left_le) begin
               entry_in = ctrl.new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ hw/rtl/sorted_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The queue accepts one enqueue or dequeue item every cycle and delivers its
// result through an output register; an item is taken while an earlier
// result waits, as long as that result is taken in the same cycle.
// The rate is set by the cell row: every cell compares its priority with the
// broadcast new priority and shifts together, so the next item sees the
// updated order at once. Entries with equal priority leave in arrival order.
// No clearing pass follows reset; only the fill count and result valid clear.
module sorted_priority_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [0:0]                  req_command,
   input  logic signed [31:0]          req_element,
   input  logic [7:0]                  req_priority_req,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_removed_element,
   output logic [1:0]                  rsp_status,
   output logic [spq_pkg::CNT_W-1:0]   rsp_occupancy
);
   import spq_pkg::*;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [31:0] rsp_removed_ff;
   logic [1:0]         rsp_status_ff;
   logic [CNT_W-1:0]   rsp_occ_ff;
   logic signed [31:0] removed_in;
   status_type         status_in;

   logic               accept;
   logic               full;
   logic               empty;
   cell_ctrl_type      ctrl;

   logic [DEPTH-1:0]   occupied;
   logic [DEPTH-1:0]   le;
   logic [DEPTH:0]     le_chain;
   entry_type          entries     [DEPTH];
   entry_type          left_entry  [DEPTH];
   entry_type          right_entry [DEPTH];

   // Handshake: the output register frees itself when its result is taken.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   // Control broadcast to the row.
   always_comb begin
      ctrl.insert          = accept && (req_command == CMD_ENQUEUE) && !full;
      ctrl.remove          = accept && (req_command == CMD_DEQUEUE) && !empty;
      ctrl.new_entry.value = req_element;
      ctrl.new_entry.prio  = req_priority_req;
   end

   // The slot ahead of the head counts as lower or equal so slot 0 can take the new entry.
   assign le_chain[0] = 1'b1;

   // Row of cells with neighbor links.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      assign occupied[k]  = (CNT_W'(k) < count_ff);
      assign le_chain[k+1] = le[k];
      if (k == 0) begin : g_first
         assign left_entry[k] = ctrl.new_entry;
      end else begin : g_mid
         assign left_entry[k] = entries[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign right_entry[k] = entries[k];
      end else begin : g_body
         assign right_entry[k] = entries[k+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied[k]),
         .left_le     (le_chain[k]),
         .left_entry  (left_entry[k]),
         .right_entry (right_entry[k]),
         .le          (le[k]),
         .entry       (entries[k])
      );
   end

   // Fill count and result of the accepted item.
   always_comb begin
      count_in   = count_ff;
      removed_in = '0;
      status_in  = STATUS_DONE;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in   = count_ff - CNT_W'(1);
         removed_in = entries[0].value;
      end else if (req_command == CMD_ENQUEUE) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_EMPTY;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded with each accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_removed_ff <= removed_in;
         rsp_status_ff  <= status_in;
         rsp_occ_ff     <= count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_removed_element = rsp_removed_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_occupancy       = rsp_occ_ff;

endmodule

@@ hw/rtl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [0:0]                  req_command,
   input  logic signed [31:0]          req_element,
   input  logic [7:0]                  req_priority_req,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [31:0]          rsp_removed_element,
   input  logic [1:0]                  rsp_status,
   input  logic [spq_pkg::CNT_W-1:0]   rsp_occupancy
);
   import spq_pkg::*;

   // A waiting input item stays offered, unchanged, until it is taken.
   `SPQ_ASSERT_NXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_command) && $stable(req_element) && $stable(req_priority_req))

   // A waiting result stays offered until it is taken.
   `SPQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A refused enqueue only happens on a full queue.
   `SPQ_ASSERT_IMP(a_full_occ, clock, reset, rsp_valid && (rsp_status == STATUS_FULL),
                   (rsp_occupancy == CNT_W'(DEPTH)) && (rsp_removed_element == '0))

   // An empty dequeue leaves the queue empty and returns zero.
   `SPQ_ASSERT_IMP(a_empty_occ, clock, reset, rsp_valid && (rsp_status == STATUS_EMPTY),
                   (rsp_occupancy == '0) && (rsp_removed_element == '0))

   // Occupancy never exceeds the queue depth.
   `SPQ_ASSERT_IMP(a_occ_range, clock, reset, rsp_valid, rsp_occupancy <= CNT_W'(DEPTH))

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
